@@ rtl/core/kprl_pkg.sv @@
package kprl_pkg;

    localparam int unsigned KEY_COUNT = 3;
    localparam int unsigned KEY_DOWN  = 0;
    localparam int unsigned KEY_UP    = 1;
    localparam int unsigned KEY_POWER = 2;

    localparam int unsigned TIME_W = 32;
    localparam int unsigned CFG_IDX_W = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_INTERVAL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONGPRESS       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_GUARD   = 2'd2;

    localparam logic [TIME_W-1:0] RST_REPEAT_INTERVAL = 32'd100_000_000;
    localparam logic [TIME_W-1:0] RST_LONGPRESS       = 32'd500_000_000;
    localparam logic [TIME_W-1:0] RST_RELEASE_GUARD   = 32'd10_000_000;

    // power key event codes
    typedef enum logic [2:0] {
        EV_NONE   = 3'd0,
        EV_ENTER  = 3'd1,
        EV_RIGHT  = 3'd2,
        EV_LEFT   = 3'd3,
        EV_ESCAPE = 3'd4
    } t_power_ev;

    typedef enum logic [2:0] {
        PH_RELEASED = 3'b001,
        PH_PRESSED  = 3'b010,
        PH_PENDING  = 3'b100
    } t_phase;

    localparam int unsigned IN_DATA_W  = 40;
    localparam int unsigned OUT_DATA_W = 8;

endpackage

@@ rtl/core/key_press_repeat_longpress_fsm.sv @@
// Key poll-tick state machine for volume down, volume up and power.
//
// Slave channel (i_s_*): one word per poll tick carrying the three active-low
// pin levels and the nanoseconds since the previous tick. Master channel
// (o_m_*): exactly one word per tick with the down and up event bits and the
// power event code (none, enter, right, left, escape).
// Config port (i_cfg_*): write index 0 repeat interval, 1 long-press time,
// 2 release guard time; other indexes are dropped. Write only while idle.
//
// The result of an accepted word is registered and shows on o_m_* in the next cycle.
// Throughput is one word per cycle while the receiver keeps up; the per-key update (saturating add of the
// timer, three compares) sits between the key state registers and the output
// register and finishes in the accepting cycle.
// o_s_tready is high while the output register is empty or being drained, so
// a stalled receiver stops intake only when a result is already waiting.
// Reset (synchronous, active low) releases every key, clears timers and flags,
// loads the default timings and empties the output register.
module key_press_repeat_longpress_fsm (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    // down_pin_level[0], up_pin_level[1], power_pin_level[2], delta_ns[34:3]
    input  logic [kprl_pkg::IN_DATA_W-1:0]  i_s_tdata,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    // down_key_event[0], up_key_event[1], power_key_event[4:2]
    output logic [kprl_pkg::OUT_DATA_W-1:0] o_m_tdata,
    input  logic                          i_cfg_we,
    input  logic [kprl_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [kprl_pkg::TIME_W-1:0]     i_cfg_wdata
);
    import kprl_pkg::*;

    logic [TIME_W-1:0] r_repeat_interval;
    logic [TIME_W-1:0] r_longpress;
    logic [TIME_W-1:0] r_release_guard;

    t_phase            r_phase  [KEY_COUNT];
    logic [TIME_W-1:0] r_timer  [KEY_COUNT];
    logic              r_repeat [KEY_COUNT];
    logic              r_lp     [KEY_COUNT];
    logic              r_power_last;

    t_phase            n_phase  [KEY_COUNT];
    logic [TIME_W-1:0] n_timer  [KEY_COUNT];
    logic              n_repeat [KEY_COUNT];
    logic              n_lp     [KEY_COUNT];

    logic [TIME_W:0]   w_sum    [KEY_COUNT];
    logic [TIME_W-1:0] w_t      [KEY_COUNT];
    logic              w_ev     [KEY_COUNT];
    logic [KEY_COUNT-1:0] w_press;
    t_power_ev         w_power_code;

    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;
    logic                  w_accept;

    assign o_s_tready = !r_out_valid || i_m_tready;
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    assign w_press[KEY_DOWN]  = !i_s_tdata[0];
    assign w_press[KEY_UP]    = !i_s_tdata[1];
    assign w_press[KEY_POWER] = !i_s_tdata[2];

    always_comb begin
        for (int k = 0; k < KEY_COUNT; k++) begin
            w_sum[k] = {1'b0, r_timer[k]} + {1'b0, i_s_tdata[34:3]};
            w_t[k]   = w_sum[k][TIME_W] ? '1 : w_sum[k][TIME_W-1:0];
            n_phase[k]  = r_phase[k];
            n_timer[k]  = w_t[k];
            n_repeat[k] = r_repeat[k];
            n_lp[k]     = r_lp[k];
            w_ev[k]     = 1'b0;
            case (r_phase[k])
                PH_RELEASED: begin
                    if (w_press[k]) begin
                        n_timer[k] = '0;
                        n_phase[k] = PH_PRESSED;
                    end
                end
                PH_PRESSED: begin
                    if (w_press[k]) begin
                        if (r_repeat[k] && w_t[k] >= r_repeat_interval) begin
                            w_ev[k]    = 1'b1;
                            n_timer[k] = '0;
                        end else if (!r_lp[k] && w_t[k] >= r_longpress) begin
                            // power reports its combo code, volume keys start repeat unless power was held
                            if (k == KEY_POWER) begin
                                w_ev[k] = 1'b1;
                            end else if (!r_power_last) begin
                                w_ev[k]     = 1'b1;
                                n_timer[k]  = '0;
                                n_repeat[k] = 1'b1;
                            end
                            n_lp[k] = 1'b1;
                        end
                    end else begin
                        if (!r_lp[k]) begin
                            w_ev[k]    = 1'b1;
                            n_phase[k] = PH_PENDING;
                        end else if (w_t[k] >= r_release_guard) begin
                            n_timer[k]  = '0;
                            n_repeat[k] = 1'b0;
                            n_lp[k]     = 1'b0;
                            n_phase[k]  = PH_RELEASED;
                        end
                    end
                end
                default: begin
                    n_timer[k]  = '0;
                    n_repeat[k] = 1'b0;
                    n_lp[k]     = 1'b0;
                    n_phase[k]  = PH_RELEASED;
                end
            endcase
        end
    end

    // power event: a short press gives enter, a long press a combo code
    always_comb begin
        w_power_code = EV_NONE;
        if (w_ev[KEY_POWER]) begin
            if (r_phase[KEY_POWER] == PH_PRESSED && w_press[KEY_POWER]) begin
                if (w_press[KEY_DOWN]) begin
                    w_power_code = EV_RIGHT;
                end else if (w_press[KEY_UP]) begin
                    w_power_code = EV_LEFT;
                end else begin
                    w_power_code = EV_ESCAPE;
                end
            end else begin
                w_power_code = EV_ENTER;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_repeat_interval <= RST_REPEAT_INTERVAL;
            r_longpress       <= RST_LONGPRESS;
            r_release_guard   <= RST_RELEASE_GUARD;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_REPEAT_INTERVAL: r_repeat_interval <= i_cfg_wdata;
                CFG_LONGPRESS:       r_longpress       <= i_cfg_wdata;
                CFG_RELEASE_GUARD:   r_release_guard   <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < KEY_COUNT; k++) begin
                r_phase[k]  <= PH_RELEASED;
                r_timer[k]  <= '0;
                r_repeat[k] <= 1'b0;
                r_lp[k]     <= 1'b0;
            end
            r_power_last <= 1'b0;
        end else if (w_accept) begin
            for (int k = 0; k < KEY_COUNT; k++) begin
                r_phase[k]  <= n_phase[k];
                r_timer[k]  <= n_timer[k];
                r_repeat[k] <= n_repeat[k];
                r_lp[k]     <= n_lp[k];
            end
            r_power_last <= w_press[KEY_POWER];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_data <= {3'b000, w_power_code, w_ev[KEY_UP], w_ev[KEY_DOWN]};
        end
    end

endmodule

@@ rtl/core/kprl_checker.sv @@
module kprl_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_s_tvalid,
    input logic                          o_s_tready,
    input logic                          o_m_tvalid,
    input logic                          i_m_tready,
    input logic [kprl_pkg::OUT_DATA_W-1:0] o_m_tdata
);
    import kprl_pkg::*;

    // one result word for every accepted tick, valid in the next cycle
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> o_m_tvalid)
        else $error("accepted word produced no result");

    // intake only stops when a result is waiting
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready)
        else $error("input stalled with empty output");

    a_power_code_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[4:2] == EV_NONE || o_m_tdata[4:2] == EV_ENTER ||
                        o_m_tdata[4:2] == EV_RIGHT || o_m_tdata[4:2] == EV_LEFT ||
                        o_m_tdata[4:2] == EV_ESCAPE))
        else $error("power event code out of range");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)))
        else $error("stalled result word changed");

endmodule

bind key_press_repeat_longpress_fsm kprl_checker u_kprl_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);
